@@ hdl/spq_pkg.sv @@
// package: shared constants, operation and status codes, result struct
`default_nettype none
package spq_pkg;

	localparam int CAPACITY_DEF      = 16;
	localparam int PRIORITY_BITS_DEF = 8;
	localparam int TAG_BITS_DEF      = 8;

	localparam int FIELD_BITS = 8;

	// operation codes
	localparam logic [1:0] FUNC_ENQ  = 2'd0;
	localparam logic [1:0] FUNC_DEQ  = 2'd1;
	localparam logic [1:0] FUNC_PEEK = 2'd2;

	// status codes
	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;

	typedef struct packed {
		logic [FIELD_BITS-1:0] out_tag;
		logic [FIELD_BITS-1:0] out_priority;
		logic                  out_valid;
		logic                  now_empty;
		logic                  now_full;
		logic [1:0]            status;
	} spq_result_t;

endpackage
`default_nettype wire

@@ hdl/spq_in_if.sv @@
// interface: request channel carrying one queue operation per item
`default_nettype none
interface spq_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [7:0] process_tag;
	logic [7:0] priority_req;

	modport source (output valid, output func, output process_tag, output priority_req,
		input ready);
	modport sink (input valid, input func, input process_tag, input priority_req,
		output ready);
endinterface
`default_nettype wire

@@ hdl/spq_out_if.sv @@
// interface: result channel carrying one result per item
`default_nettype none
interface spq_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_tag;
	logic [7:0] out_priority;
	logic       out_valid;
	logic       now_empty;
	logic       now_full;
	logic [1:0] status;

	modport source (output valid, output out_tag, output out_priority, output out_valid,
		output now_empty, output now_full, output status, input ready);
	modport sink (input valid, input out_tag, input out_priority, input out_valid,
		input now_empty, input now_full, input status, output ready);
endinterface
`default_nettype wire

@@ hdl/sorted_priority_queue.sv @@
// top level: sorted priority queue of process tags with registered result output
//
// Bounded priority queue of up to CAPACITY process tags, kept sorted by priority
// with the lowest number at the head; equal priorities leave in arrival order.
// Every item on in_ch (enqueue, dequeue or peek) yields exactly one result on
// out_ch with the head entry where one applies, empty/full flags after the
// operation and a status code (full on enqueue, empty on dequeue or peek are
// rejected and leave the queue untouched). The entries live in a memory with
// one write port and one registered read port, and one sequencer walks it
// one entry per cycle: an enqueue compares and moves the entries behind the
// insertion point, a dequeue shifts the remaining entries forward and a peek
// reads the head; rejected or unused operations go straight to the result.
// The result is then handed to the output register, which lets the next item
// enter while the result waits to be taken. in_ch is ready only between items.
// Reset empties the queue at once; no clearing pass is needed.
`default_nettype none
module sorted_priority_queue #(
	parameter int CAPACITY      = spq_pkg::CAPACITY_DEF,
	parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF,
	parameter int TAG_BITS      = spq_pkg::TAG_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	spq_in_if.sink    in_ch,
	spq_out_if.source out_ch
);
	import spq_pkg::*;

	spq_result_t res;
	logic        res_vld;
	logic        res_ready;
	spq_result_t out_q;
	logic        out_vld_q;

	// sequencer and entry store
	spq_seq #(
		.CAPACITY      (CAPACITY),
		.PRIORITY_BITS (PRIORITY_BITS),
		.TAG_BITS      (TAG_BITS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.res_vld   (res_vld),
		.res       (res),
		.res_ready (res_ready)
	);

	// output register takes a result when empty or being drained this cycle
	assign res_ready = !out_vld_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			out_q     <= '0;
		end else begin
			if (res_vld && res_ready) begin
				out_vld_q <= 1'b1;
				out_q     <= res;
			end else if (out_ch.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign out_ch.valid        = out_vld_q;
	assign out_ch.out_tag      = out_q.out_tag;
	assign out_ch.out_priority = out_q.out_priority;
	assign out_ch.out_valid    = out_q.out_valid;
	assign out_ch.now_empty    = out_q.now_empty;
	assign out_ch.now_full     = out_q.now_full;
	assign out_ch.status       = out_q.status;

endmodule
`default_nettype wire

@@ hdl/spq_ram.sv @@
// module: entry store, one write port and one registered read port
`default_nettype none
module spq_ram #(
	parameter int DEPTH = 16,
	parameter int AW    = 4,
	parameter int DW    = 16
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

@@ hdl/spq_seq.sv @@
// module: operation sequencer walking the entry store one entry per cycle
`default_nettype none
module spq_seq #(
	parameter int CAPACITY      = 16,
	parameter int PRIORITY_BITS = 8,
	parameter int TAG_BITS      = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	spq_in_if.sink             in_ch,
	output logic               res_vld,
	output spq_pkg::spq_result_t res,
	input  wire logic          res_ready
);
	import spq_pkg::*;

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int DW = TAG_BITS + PRIORITY_BITS;

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_ENQ_CMP = 3'd1;
	localparam logic [2:0] S_ENQ_PUT = 3'd2;
	localparam logic [2:0] S_HEAD    = 3'd3;
	localparam logic [2:0] S_SHIFT   = 3'd4;
	localparam logic [2:0] S_DONE    = 3'd5;

	logic [2:0]               state_q;
	logic [CW-1:0]            cnt_q;
	logic [IW-1:0]            idx_q;
	logic [1:0]               func_q;
	logic [TAG_BITS-1:0]      tag_q;
	logic [PRIORITY_BITS-1:0] prio_q;
	logic [TAG_BITS-1:0]      head_tag_q;
	logic [PRIORITY_BITS-1:0] head_prio_q;
	logic                     head_vld_q;
	logic [1:0]               status_q;

	logic                     we;
	logic [IW-1:0]            waddr;
	logic [DW-1:0]            wdata;
	logic [IW-1:0]            raddr;
	logic [DW-1:0]            rdata;
	logic [TAG_BITS-1:0]      rd_tag;
	logic [PRIORITY_BITS-1:0] rd_prio;
	logic                     rd_gt;
	logic [CW-1:0]            cnt_m1;
	logic                     accept;
	logic [TAG_BITS+7:0]      tag_in_ext;
	logic [PRIORITY_BITS+7:0] prio_in_ext;
	logic [TAG_BITS+7:0]      tag_out_ext;
	logic [PRIORITY_BITS+7:0] prio_out_ext;

	assign rd_tag  = rdata[DW-1:PRIORITY_BITS];
	assign rd_prio = rdata[PRIORITY_BITS-1:0];
	// the single compare unit: stored entry strictly behind the new one
	assign rd_gt   = rd_prio > prio_q;
	assign cnt_m1  = cnt_q - 1'b1;

	assign in_ch.ready = (state_q == S_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;

	// fit the 8-bit fields to the stored widths and back
	assign tag_in_ext   = {{TAG_BITS{1'b0}}, in_ch.process_tag};
	assign prio_in_ext  = {{PRIORITY_BITS{1'b0}}, in_ch.priority_req};
	assign tag_out_ext  = {8'h00, head_tag_q};
	assign prio_out_ext = {8'h00, head_prio_q};

	spq_ram #(
		.DEPTH (CAPACITY),
		.AW    (IW),
		.DW    (DW)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// store port control
	always_comb begin
		we    = 1'b0;
		waddr = idx_q;
		wdata = {tag_q, prio_q};
		raddr = idx_q;
		case (state_q)
			S_IDLE: begin
				raddr = (in_ch.func == FUNC_ENQ) ? cnt_m1[IW-1:0] : '0;
			end
			S_ENQ_CMP: begin
				// move the entry up a slot, or drop the new one in behind it
				raddr = idx_q - 1'b1;
				we    = 1'b1;
				waddr = idx_q + 1'b1;
				wdata = rd_gt ? rdata : {tag_q, prio_q};
			end
			S_ENQ_PUT: begin
				we    = 1'b1;
				waddr = '0;
			end
			S_HEAD: begin
				raddr = IW'(1);
			end
			S_SHIFT: begin
				raddr = idx_q + 1'b1;
				we    = 1'b1;
				waddr = idx_q - 1'b1;
				wdata = rdata;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			idx_q       <= '0;
			func_q      <= FUNC_ENQ;
			tag_q       <= '0;
			prio_q      <= '0;
			head_tag_q  <= '0;
			head_prio_q <= '0;
			head_vld_q  <= 1'b0;
			status_q    <= STATUS_OK;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						func_q      <= in_ch.func;
						tag_q       <= tag_in_ext[TAG_BITS-1:0];
						prio_q      <= prio_in_ext[PRIORITY_BITS-1:0];
						head_tag_q  <= '0;
						head_prio_q <= '0;
						head_vld_q  <= 1'b0;
						status_q    <= STATUS_OK;
						case (in_ch.func)
							FUNC_ENQ: begin
								if (cnt_q == CW'(CAPACITY)) begin
									status_q <= STATUS_FULL;
									state_q  <= S_DONE;
								end else if (cnt_q == '0) begin
									state_q <= S_ENQ_PUT;
								end else begin
									idx_q   <= cnt_m1[IW-1:0];
									state_q <= S_ENQ_CMP;
								end
							end
							FUNC_DEQ, FUNC_PEEK: begin
								if (cnt_q == '0) begin
									status_q <= STATUS_EMPTY;
									state_q  <= S_DONE;
								end else begin
									state_q <= S_HEAD;
								end
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_ENQ_CMP: begin
					if (rd_gt) begin
						if (idx_q == '0) begin
							state_q <= S_ENQ_PUT;
						end else begin
							idx_q <= idx_q - 1'b1;
						end
					end else begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= S_DONE;
					end
				end
				S_ENQ_PUT: begin
					cnt_q   <= cnt_q + 1'b1;
					state_q <= S_DONE;
				end
				S_HEAD: begin
					head_tag_q  <= rd_tag;
					head_prio_q <= rd_prio;
					head_vld_q  <= 1'b1;
					if (func_q == FUNC_PEEK) begin
						state_q <= S_DONE;
					end else if (cnt_q == CW'(1)) begin
						cnt_q   <= cnt_m1;
						state_q <= S_DONE;
					end else begin
						idx_q   <= IW'(1);
						state_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					if (CW'(idx_q) == cnt_m1) begin
						cnt_q   <= cnt_m1;
						state_q <= S_DONE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign res_vld          = (state_q == S_DONE);
	assign res.out_tag      = tag_out_ext[7:0];
	assign res.out_priority = prio_out_ext[7:0];
	assign res.out_valid    = head_vld_q;
	assign res.now_empty    = (cnt_q == '0);
	assign res.now_full     = (cnt_q == CW'(CAPACITY));
	assign res.status       = status_q;

endmodule
`default_nettype wire

@@ tb/sorted_priority_queue_tb.sv @@
// testbench: sorted priority queue checked against a behavioral queue model in a scoreboard
`timescale 1ns / 100ps

class spq_scoreboard;
	localparam int DEPTH = spq_pkg::CAPACITY_DEF;

	logic [7:0]           tag_store [DEPTH];
	logic [7:0]           prio_store [DEPTH];
	int unsigned          held;
	spq_pkg::spq_result_t pending_results [$];
	int unsigned          errors;
	int unsigned          checked;
	int unsigned          enq_taken;
	int unsigned          full_rejects;
	int unsigned          empty_rejects;
	int unsigned          full_reached;

	function new();
		held          = 0;
		errors        = 0;
		checked       = 0;
		enq_taken     = 0;
		full_rejects  = 0;
		empty_rejects = 0;
		full_reached  = 0;
	endfunction

	// apply one accepted request to the queue copy and queue up its result
	function void note_request(logic [1:0] func, logic [7:0] tag, logic [7:0] prio);
		spq_pkg::spq_result_t r;
		int unsigned          pos;
		int unsigned          i;
		r        = '0;
		r.status = spq_pkg::STATUS_OK;
		case (func)
			spq_pkg::FUNC_ENQ: begin
				if (held == DEPTH) begin
					r.status = spq_pkg::STATUS_FULL;
					full_rejects++;
				end else begin
					pos = 0;
					while (pos < held && prio_store[pos] <= prio)
						pos++;
					for (i = held; i > pos; i--) begin
						tag_store[i]  = tag_store[i-1];
						prio_store[i] = prio_store[i-1];
					end
					tag_store[pos]  = tag;
					prio_store[pos] = prio;
					held++;
					enq_taken++;
					if (held == DEPTH)
						full_reached++;
				end
			end
			spq_pkg::FUNC_DEQ, spq_pkg::FUNC_PEEK: begin
				if (held == 0) begin
					r.status = spq_pkg::STATUS_EMPTY;
					empty_rejects++;
				end else begin
					r.out_tag      = tag_store[0];
					r.out_priority = prio_store[0];
					r.out_valid    = 1'b1;
					if (func == spq_pkg::FUNC_DEQ) begin
						for (i = 1; i < held; i++) begin
							tag_store[i-1]  = tag_store[i];
							prio_store[i-1] = prio_store[i];
						end
						held--;
					end
				end
			end
			default: ;
		endcase
		r.now_empty = (held == 0);
		r.now_full  = (held == DEPTH);
		pending_results.push_back(r);
	endfunction

	function void check_result(spq_pkg::spq_result_t got);
		spq_pkg::spq_result_t want;
		if (pending_results.size() == 0) begin
			$error("result with no request outstanding: tag %0d priority %0d status %0d",
				got.out_tag, got.out_priority, got.status);
			errors++;
			return;
		end
		want = pending_results.pop_front();
		checked++;
		if (got.out_tag !== want.out_tag) begin
			$error("out_tag: expected %0d, got %0d", want.out_tag, got.out_tag);
			errors++;
		end
		if (got.out_priority !== want.out_priority) begin
			$error("out_priority: expected %0d, got %0d", want.out_priority, got.out_priority);
			errors++;
		end
		if (got.out_valid !== want.out_valid) begin
			$error("out_valid: expected %0d, got %0d", want.out_valid, got.out_valid);
			errors++;
		end
		if (got.now_empty !== want.now_empty) begin
			$error("now_empty: expected %0d, got %0d", want.now_empty, got.now_empty);
			errors++;
		end
		if (got.now_full !== want.now_full) begin
			$error("now_full: expected %0d, got %0d", want.now_full, got.now_full);
			errors++;
		end
		if (got.status !== want.status) begin
			$error("status: expected %0d, got %0d", want.status, got.status);
			errors++;
		end
	endfunction
endclass

module sorted_priority_queue_tb;
	import spq_pkg::*;

	// code 3 is unused by the block and must act as a no-op
	localparam logic [1:0] FUNC_NOP = 2'd3;
	localparam int CYCLE_LIMIT = 1_000_000;
	// slowest item: full-depth enqueue walk plus hand-off to the output register
	localparam int SETTLE_CYCLES = 2 * CAPACITY_DEF + 8;
	localparam int LONG_HOLD = 250;
	localparam int PHASE_ITEMS = 642;

	logic clk = 1'b0;
	logic arst_n;

	spq_in_if  in_ch ();
	spq_out_if out_ch ();

	sorted_priority_queue u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	spq_scoreboard sb;

	// idle percentages per cycle for each side, changed between phases
	int unsigned send_idle_pct = 0;
	int unsigned take_idle_pct = 0;
	// a long receiver stall, set by the sender and counted down by the receiver
	int unsigned hold_request = 0;
	int unsigned long_holds = 0;
	int unsigned cycle_count = 0;

	always #6 clk = ~clk;

	// watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// receiver: sample results at the edge, then pick ready for the next cycle
	initial begin : receiver
		int unsigned          hold_left;
		spq_pkg::spq_result_t got;
		hold_left = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_ch.valid && out_ch.ready) begin
				got.out_tag      = out_ch.out_tag;
				got.out_priority = out_ch.out_priority;
				got.out_valid    = out_ch.out_valid;
				got.now_empty    = out_ch.now_empty;
				got.now_full     = out_ch.now_full;
				got.status       = out_ch.status;
				sb.check_result(got);
			end
			if (hold_request != 0) begin
				hold_left    = hold_request;
				hold_request = 0;
				long_holds++;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= take_idle_pct);
			end
		end
	end

	// offer one item, idling first at random; note it in the scoreboard once taken
	task automatic send_item(input logic [1:0] func, input logic [7:0] tag,
		input logic [7:0] prio);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid        <= 1'b1;
		in_ch.func         <= func;
		in_ch.process_tag  <= tag;
		in_ch.priority_req <= prio;
		do
			@(posedge clk);
		while (!in_ch.ready);
		sb.note_request(func, tag, prio);
	endtask

	// hold the sender until every result already owed has come back
	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (sb.pending_results.size() != 0)
			@(posedge clk);
	endtask

	// empty-queue rejects, no-op, boundary values, ties, fill to full and reject
	task automatic directed_items();
		int i;
		send_item(FUNC_PEEK, 8'h00, 8'h00);
		send_item(FUNC_DEQ, 8'hFF, 8'hFF);
		send_item(FUNC_NOP, 8'hFF, 8'hFF);
		send_item(FUNC_ENQ, 8'hFF, 8'hFF);
		send_item(FUNC_ENQ, 8'h00, 8'h00);
		// equal priorities must leave in arrival order
		send_item(FUNC_ENQ, 8'hAA, 8'h80);
		send_item(FUNC_ENQ, 8'h55, 8'h80);
		send_item(FUNC_PEEK, 8'h00, 8'h00);
		send_item(FUNC_NOP, 8'h5A, 8'hA5);
		// twelve more reach capacity, landing between and on top of existing ties
		for (i = 0; i < 12; i++)
			send_item(FUNC_ENQ, 8'(8'h10 + i), 8'(((i * 7) % 4) * 8'h40));
		send_item(FUNC_ENQ, 8'h77, 8'h01);
		send_item(FUNC_PEEK, 8'h00, 8'h00);
		send_item(FUNC_DEQ, 8'h00, 8'h00);
		send_item(FUNC_DEQ, 8'h00, 8'h00);
	endtask

	// random traffic steered in stretches toward filling, draining or balance,
	// so the queue swings between empty and full over and over
	task automatic random_items(input int n_items, input bit with_hold);
		int         k;
		int unsigned bias;
		int unsigned enq_cut;
		int unsigned roll;
		logic [1:0] func;
		logic [7:0] tag;
		logic [7:0] prio;
		bias = 0;
		for (k = 0; k < n_items; k++) begin
			if (k % 40 == 0)
				bias = $urandom_range(2);
			enq_cut = (bias == 0) ? 80 : (bias == 1) ? 35 : 56;
			roll = $urandom_range(99);
			if (roll < 3)
				func = FUNC_NOP;
			else if (roll < 13)
				func = FUNC_PEEK;
			else if (roll < enq_cut)
				func = FUNC_ENQ;
			else
				func = FUNC_DEQ;
			tag  = 8'($urandom_range(255));
			roll = $urandom_range(99);
			// narrow priorities most of the time so ties are common
			if (roll < 50)
				prio = 8'($urandom_range(3));
			else if (roll < 60)
				prio = (roll < 55) ? 8'h00 : 8'hFF;
			else
				prio = 8'($urandom_range(255));
			// long receiver stall while items keep coming: input must back up
			if (with_hold && k == n_items / 2)
				hold_request = LONG_HOLD;
			if (k == n_items / 3)
				wait_drained();
			send_item(func, tag, prio);
		end
	endtask

	initial begin : stimulus
		sb = new();
		arst_n             <= 1'b0;
		in_ch.valid        <= 1'b0;
		in_ch.func         <= FUNC_ENQ;
		in_ch.process_tag  <= 8'h00;
		in_ch.priority_req <= 8'h00;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sender idles lightly, receiver heavily
		send_idle_pct = 21;
		take_idle_pct = 46;
		directed_items();
		random_items(PHASE_ITEMS, 1'b1);
		wait_drained();

		// roles swapped
		send_idle_pct = 46;
		take_idle_pct = 21;
		random_items(PHASE_ITEMS, 1'b1);
		wait_drained();

		// full rate on both sides
		send_idle_pct = 0;
		take_idle_pct = 0;
		random_items(PHASE_ITEMS, 1'b0);
		wait_drained();

		// let any straggling result show up as unexpected
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d results: %0d enqueues taken, %0d full and %0d empty rejects",
			sb.checked, sb.enq_taken, sb.full_rejects, sb.empty_rejects);
		$display("queue reached capacity %0d times; %0d long output stalls",
			sb.full_reached, long_holds);
		if (sb.errors == 0 && sb.pending_results.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
